### rtl/core/aabb_pair_collision_masked_assert.svh
// assertion helpers for the collision block, all clocked on clk and off during reset
`ifndef AABB_PAIR_COLLISION_MASKED_ASSERT_SVH
`define AABB_PAIR_COLLISION_MASKED_ASSERT_SVH

// same-cycle implication
`define APCM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define APCM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition that must never hold
`define APCM_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

### rtl/core/aabb_pc_pkg.sv
package aabb_pc_pkg;

	localparam int unsigned MAX_OBJECTS_DEF = 32;
	localparam int unsigned ID_W = 64;
	localparam int unsigned COORD_W = 16;
	localparam int unsigned SIZE_W = 15;
	localparam int unsigned BITS_W = 32;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
		logic [BITS_W-1:0] layer;
		logic [BITS_W-1:0] mask;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0] owner;
		logic [ID_W-1:0] other;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
	} record_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_TEST,
		ST_EMIT_A,
		ST_EMIT_B,
		ST_STORE,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic load_cur;
		logic load_res;
		logic push_a;
		logic push_b;
		logic flush;
		logic wr_en;
	} dp_cmd_t;

	typedef struct packed {
		logic hit_a;
		logic hit_b;
		logic res_b;
		logic push_ok;
		logic flush_ok;
		logic pend_v;
	} dp_status_t;

endpackage

### rtl/core/aabb_pc_if.sv
interface aabb_pc_obj_if import aabb_pc_pkg::*; ();
	logic valid;
	logic ready;
	logic [ID_W-1:0] object_id;
	logic signed [COORD_W-1:0] rect_x;
	logic signed [COORD_W-1:0] rect_y;
	logic [SIZE_W-1:0] rect_w;
	logic [SIZE_W-1:0] rect_h;
	logic [BITS_W-1:0] layer_bits;
	logic [BITS_W-1:0] mask_bits;
	logic active;
	logic frame_end;

	modport source (
		output valid, object_id, rect_x, rect_y, rect_w, rect_h, layer_bits, mask_bits,
		output active, frame_end,
		input ready
	);
	modport sink (
		input valid, object_id, rect_x, rect_y, rect_w, rect_h, layer_bits, mask_bits,
		input active, frame_end,
		output ready
	);
endinterface

interface aabb_pc_hit_if import aabb_pc_pkg::*; ();
	logic valid;
	logic ready;
	logic [ID_W-1:0] owner_id;
	logic [ID_W-1:0] other_id;
	logic signed [COORD_W-1:0] hit_x;
	logic signed [COORD_W-1:0] hit_y;
	logic [SIZE_W-1:0] hit_w;
	logic [SIZE_W-1:0] hit_h;
	logic run_last;

	modport source (
		output valid, owner_id, other_id, hit_x, hit_y, hit_w, hit_h, run_last,
		input ready
	);
	modport sink (
		input valid, owner_id, other_id, hit_x, hit_y, hit_w, hit_h, run_last,
		output ready
	);
endinterface

### rtl/core/aabb_pc_dp.sv
module aabb_pc_dp import aabb_pc_pkg::*; #(
	parameter int unsigned MAX_OBJECTS = MAX_OBJECTS_DEF,
	localparam int unsigned IDX_W = $clog2(MAX_OBJECTS)
) (
	input logic clk,
	input logic arst_n,
	input item_t item,
	input dp_cmd_t cmd,
	output dp_status_t stat,
	input logic [IDX_W-1:0] rd_addr,
	input logic [IDX_W-1:0] wr_addr,
	aabb_pc_hit_if.source hit
);

	item_t mem_q [MAX_OBJECTS];
	item_t cur_q;
	item_t rd_q;

	logic signed [COORD_W:0] a_r, b_r, a_b, b_b, rx, by2, ow, oh;
	logic signed [COORD_W-1:0] lx, ty;
	logic empty, overlap;

	logic [ID_W-1:0] res_id_q;
	logic signed [COORD_W-1:0] res_x_q, res_y_q;
	logic [SIZE_W-1:0] res_w_q, res_h_q;
	logic res_b_q;

	record_t rec_new;
	record_t pend_q;
	record_t out_q;
	logic out_last_q;
	logic pend_v_q, out_v_q;
	logic push, take;

	// store and current object
	always_ff @(posedge clk) begin
		if (cmd.load_cur) begin
			cur_q <= item;
		end
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= cur_q;
		end
		rd_q <= mem_q[rd_addr];
	end

	// overlap of the current object with the entry just read
	always_comb begin
		a_r = $signed({cur_q.x[COORD_W-1], cur_q.x}) + $signed({2'b00, cur_q.w});
		b_r = $signed({rd_q.x[COORD_W-1], rd_q.x}) + $signed({2'b00, rd_q.w});
		a_b = $signed({cur_q.y[COORD_W-1], cur_q.y}) + $signed({2'b00, cur_q.h});
		b_b = $signed({rd_q.y[COORD_W-1], rd_q.y}) + $signed({2'b00, rd_q.h});
		lx = ($signed(cur_q.x) > $signed(rd_q.x)) ? cur_q.x : rd_q.x;
		ty = ($signed(cur_q.y) > $signed(rd_q.y)) ? cur_q.y : rd_q.y;
		rx = (a_r < b_r) ? a_r : b_r;
		by2 = (a_b < b_b) ? a_b : b_b;
		ow = rx - $signed({lx[COORD_W-1], lx});
		oh = by2 - $signed({ty[COORD_W-1], ty});
		empty = ~|cur_q.w | ~|cur_q.h | ~|rd_q.w | ~|rd_q.h;
		overlap = !empty && (ow > 17'sd0) && (oh > 17'sd0);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			res_id_q <= rd_q.id;
			res_x_q <= lx;
			res_y_q <= ty;
			res_w_q <= ow[SIZE_W-1:0];
			res_h_q <= oh[SIZE_W-1:0];
			res_b_q <= overlap && (|(rd_q.mask & cur_q.layer));
		end
	end

	always_comb begin
		rec_new.owner = cmd.push_a ? cur_q.id : res_id_q;
		rec_new.other = cmd.push_a ? res_id_q : cur_q.id;
		rec_new.x = res_x_q;
		rec_new.y = res_y_q;
		rec_new.w = res_w_q;
		rec_new.h = res_h_q;
	end

	assign push = cmd.push_a | cmd.push_b;
	assign take = out_v_q & hit.ready;

	// one record is held back so the last one of an item can be marked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else if (push) begin
			pend_v_q <= 1'b1;
			out_v_q <= pend_v_q | (out_v_q & ~take);
		end else if (cmd.flush) begin
			pend_v_q <= 1'b0;
			out_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			pend_q <= rec_new;
			if (pend_v_q) begin
				out_q <= pend_q;
				out_last_q <= 1'b0;
			end
		end else if (cmd.flush) begin
			out_q <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	assign hit.valid = out_v_q;
	assign hit.owner_id = out_q.owner;
	assign hit.other_id = out_q.other;
	assign hit.hit_x = out_q.x;
	assign hit.hit_y = out_q.y;
	assign hit.hit_w = out_q.w;
	assign hit.hit_h = out_q.h;
	assign hit.run_last = out_last_q;

	always_comb begin
		stat.hit_a = overlap && (|(cur_q.mask & rd_q.layer));
		stat.hit_b = overlap && (|(rd_q.mask & cur_q.layer));
		stat.res_b = res_b_q;
		stat.push_ok = !pend_v_q || !out_v_q || hit.ready;
		stat.flush_ok = !out_v_q || hit.ready;
		stat.pend_v = pend_v_q;
	end

endmodule

### rtl/core/aabb_pc_ctrl.sv
module aabb_pc_ctrl import aabb_pc_pkg::*; #(
	parameter int unsigned MAX_OBJECTS = MAX_OBJECTS_DEF,
	localparam int unsigned IDX_W = $clog2(MAX_OBJECTS),
	localparam int unsigned CNT_W = $clog2(MAX_OBJECTS + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_active,
	input logic in_frame_end,
	output logic in_ready,
	output dp_cmd_t cmd,
	input dp_status_t stat,
	output logic [IDX_W-1:0] rd_addr,
	output logic [IDX_W-1:0] wr_addr
);

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OBJECTS);

	state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic fe_q, fe_d;
	logic [CNT_W-1:0] idx_nxt;
	logic last;

	assign idx_nxt = CNT_W'(idx_q) + CNT_W'(1);
	assign last = (idx_nxt >= count_q);
	assign wr_addr = count_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			count_q <= '0;
			fe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			count_q <= count_d;
			fe_q <= fe_d;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		count_d = count_q;
		fe_d = fe_q;
		cmd = '0;
		in_ready = 1'b0;
		rd_addr = idx_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					fe_d = in_frame_end;
					cmd.load_cur = 1'b1;
					if (in_active && (count_q != CNT_MAX)) begin
						idx_d = '0;
						state_d = (count_q == '0) ? ST_STORE : ST_FETCH;
					end else if (in_frame_end) begin
						count_d = '0;
					end
				end
			end
			ST_FETCH: begin
				state_d = ST_TEST;
			end
			ST_TEST: begin
				// read ahead so a miss moves straight on to test the next entry
				rd_addr = idx_nxt[IDX_W-1:0];
				cmd.load_res = 1'b1;
				if (stat.hit_a) begin
					state_d = ST_EMIT_A;
				end else if (stat.hit_b) begin
					state_d = ST_EMIT_B;
				end else if (last) begin
					state_d = ST_STORE;
				end else begin
					idx_d = idx_nxt[IDX_W-1:0];
				end
			end
			ST_EMIT_A: begin
				if (stat.push_ok) begin
					cmd.push_a = 1'b1;
					if (stat.res_b) begin
						state_d = ST_EMIT_B;
					end else if (last) begin
						state_d = ST_STORE;
					end else begin
						idx_d = idx_nxt[IDX_W-1:0];
						state_d = ST_FETCH;
					end
				end
			end
			ST_EMIT_B: begin
				if (stat.push_ok) begin
					cmd.push_b = 1'b1;
					if (last) begin
						state_d = ST_STORE;
					end else begin
						idx_d = idx_nxt[IDX_W-1:0];
						state_d = ST_FETCH;
					end
				end
			end
			ST_STORE: begin
				cmd.wr_en = 1'b1;
				count_d = count_q + CNT_W'(1);
				state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!stat.pend_v || stat.flush_ok) begin
					cmd.flush = stat.pend_v;
					if (fe_q) begin
						count_d = '0;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/aabb_pair_collision_masked.sv
// masked rectangle collision finder, one frame of objects at a time
// obj channel: one collider object per transfer (valid/ready). an active object is
// tested against every object stored so far in the frame, then appended to the store;
// frame_end empties the store once the object has been handled. active objects that
// arrive with the store full are dropped
// hit channel: one record per transfer for each reported direction of a hit, the
// record owned by the new object first; run_last marks the last record of an object
// timing: the store is scanned one entry per cycle through a registered memory read
// while entries miss; an object with an empty store goes straight to the store write.
// a hit on an entry that is not the last makes the scan re-read the store before it
// goes on. an inactive or dropped object is handled in the idle state with no scan.
// a record is held back until the next record of the object is formed or the scan
// ends, and shows on the hit port in the cycle after that
// reset empties the store and the output; no clearing pass is needed
// a stalled hit receiver holds the scan once the output register and the one held-back
// record are both full; the next object is taken only after the last record of the
// current one has moved into the output register
`include "aabb_pair_collision_masked_assert.svh"

module aabb_pair_collision_masked import aabb_pc_pkg::*; #(
	parameter int unsigned MAX_OBJECTS = MAX_OBJECTS_DEF
) (
	input logic clk,
	input logic arst_n,
	aabb_pc_obj_if.sink obj,
	aabb_pc_hit_if.source hit
);

	localparam int unsigned IDX_W = $clog2(MAX_OBJECTS);

	dp_cmd_t cmd;
	dp_status_t stat;
	item_t item;
	logic in_ready;
	logic [IDX_W-1:0] rd_addr, wr_addr;

	assign obj.ready = in_ready;

	always_comb begin
		item.id = obj.object_id;
		item.x = obj.rect_x;
		item.y = obj.rect_y;
		item.w = obj.rect_w;
		item.h = obj.rect_h;
		item.layer = obj.layer_bits;
		item.mask = obj.mask_bits;
	end

	aabb_pc_ctrl #(
		.MAX_OBJECTS(MAX_OBJECTS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(obj.valid),
		.in_active(obj.active),
		.in_frame_end(obj.frame_end),
		.in_ready(in_ready),
		.cmd(cmd),
		.stat(stat),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr)
	);

	aabb_pc_dp #(
		.MAX_OBJECTS(MAX_OBJECTS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cmd(cmd),
		.stat(stat),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.hit(hit)
	);

	`APCM_ASSERT_IMP(a_idle_no_pending, obj.ready, !stat.pend_v, "record left pending at idle")
	`APCM_ASSERT_IMP(a_push_room, cmd.push_a || cmd.push_b, stat.push_ok, "push with no room")
	`APCM_ASSERT_NXT(a_flush_marks_last, cmd.flush, hit.valid && hit.run_last, "flush not last")
	`APCM_ASSERT_NEVER(a_push_flush, cmd.flush && (cmd.push_a || cmd.push_b), "push and flush")

endmodule
